### rtl/etc_pkg.sv
// Package: payload types, table constants and shared codes for the traffic counters.
package etc_pkg;

  localparam int MAC_ENTRIES_DEF  = 256;
  localparam int IP_ENTRIES_DEF   = 256;
  localparam int CONV_ENTRIES_DEF = 256;

  localparam logic [1:0] CMD_UPDATE   = 2'd0;
  localparam logic [1:0] CMD_READ_MAC = 2'd1;
  localparam logic [1:0] CMD_READ_IP  = 2'd2;
  localparam logic [1:0] CMD_READ_CNV = 2'd3;

  localparam logic [1:0] CLS_TCP   = 2'd0;
  localparam logic [1:0] CLS_UDP   = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  ip_proto;
    logic [15:0] l4_src_port;
    logic [15:0] l4_dst_port;
    logic [15:0] frame_len;
    logic [7:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic        entry_valid;
    logic [47:0] entry_address;
    logic [31:0] tx_pkts;
    logic [31:0] rx_pkts;
    logic [31:0] tx_bytes;
    logic [31:0] rx_bytes;
    logic [31:0] conv_src_ip;
    logic [31:0] conv_dst_ip;
    logic [15:0] conv_src_port;
    logic [15:0] conv_dst_port;
    logic [1:0]  conv_protocol;
    logic        table_overflow;
  } out_item_t;

  // Request to a keyed counter table.
  typedef enum logic [1:0] {
    TOP_COUNT = 2'd0,
    TOP_READ  = 2'd1
  } tbl_op_t;

  typedef struct packed {
    logic        start;
    tbl_op_t     op;
    logic [47:0] skey;
    logic [47:0] dkey;
    logic [15:0] len;
    logic [7:0]  idx;
  } tbl_req_t;

  typedef struct packed {
    logic         done;
    logic         hit;
    logic         drop;
    logic [47:0]  key;
    logic [127:0] cnt;
  } tbl_rsp_t;

  typedef enum logic [3:0] {
    TS_IDLE,
    TS_SCAN_REQ,
    TS_SCAN_CHK,
    TS_CNT_RD,
    TS_CNT_WAIT,
    TS_CNT_WR,
    TS_RD_WAIT,
    TS_RD_DATA,
    TS_DONE
  } tbl_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_REQ,
    CS_CHK,
    CS_RD_WAIT,
    CS_RD_DATA,
    CS_DONE
  } cnv_state_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_RUN,
    MS_WAIT,
    MS_OUT
  } main_state_t;

endpackage

### rtl/etc_table.sv
// Keyed counter table: linear key search, insert, counter read-modify-write and indexed entry read.
module etc_table #(
  parameter int ENTRIES = etc_pkg::MAC_ENTRIES_DEF,
  parameter int KEY_W   = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  etc_pkg::tbl_req_t req,
  output etc_pkg::tbl_rsp_t rsp
);
  import etc_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW = $clog2(ENTRIES + 1);

  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [127:0]     cnt_mem [ENTRIES];

  tbl_state_t state_r, state_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic [UW-1:0] scan_r, scan_nxt;
  logic          side_r, side_nxt;     // 0 source, 1 destination
  logic          drop_r, drop_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  tbl_req_t      req_r;

  logic             key_we, cnt_we;
  logic [AW-1:0]    key_waddr, cnt_waddr, key_raddr, cnt_raddr;
  logic [KEY_W-1:0] key_wdata, key_rdata_r;
  logic [127:0]     cnt_wdata, cnt_rdata_r;
  logic [KEY_W-1:0] cur_key;
  logic             rd_ok;

  assign cur_key = side_r ? req_r.dkey[KEY_W-1:0] : req_r.skey[KEY_W-1:0];
  assign rd_ok   = ({{(32-UW){1'b0}}, used_r} > {24'd0, req_r.idx})
                && ({24'd0, req_r.idx} < 32'(ENTRIES));

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_waddr] <= key_wdata;
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    key_rdata_r <= key_mem[key_raddr];
    cnt_rdata_r <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TS_IDLE;
      used_r  <= '0;
      scan_r  <= '0;
      side_r  <= 1'b0;
      drop_r  <= 1'b0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      scan_r  <= scan_nxt;
      side_r  <= side_nxt;
      drop_r  <= drop_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) req_r <= req;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TS_IDLE:     if (req.start) state_nxt = (req.op == TOP_READ) ? TS_RD_WAIT : TS_SCAN_REQ;
      TS_SCAN_REQ: state_nxt = (scan_r < used_r) ? TS_SCAN_CHK : TS_CNT_RD;
      TS_SCAN_CHK: state_nxt = (key_rdata_r == cur_key) ? TS_CNT_RD : TS_SCAN_REQ;
      TS_CNT_RD:   state_nxt = TS_CNT_WAIT;
      TS_CNT_WAIT: state_nxt = TS_CNT_WR;
      TS_CNT_WR:   state_nxt = side_r ? TS_DONE : TS_SCAN_REQ;
      TS_RD_WAIT:  state_nxt = TS_RD_DATA;
      TS_RD_DATA:  state_nxt = TS_DONE;
      TS_DONE:     state_nxt = TS_IDLE;
      default:     state_nxt = TS_IDLE;
    endcase
  end

  // Hit/miss bookkeeping; a miss on a full table sets drop and suppresses the counter write.
  logic miss_full_r, miss_full_nxt;
  logic new_ent_r, new_ent_nxt;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_full_r <= 1'b0;
      new_ent_r   <= 1'b0;
    end else begin
      miss_full_r <= miss_full_nxt;
      new_ent_r   <= new_ent_nxt;
    end
  end

  logic [127:0] base, upd;
  logic [31:0]  len32;
  assign len32 = {16'd0, req_r.len};
  assign base  = new_ent_r ? '0 : cnt_rdata_r;
  always_comb begin
    upd = base;
    if (side_r) begin
      upd[95:64] = base[95:64] + 32'd1;
      upd[31:0]  = base[31:0] + len32;
    end else begin
      upd[127:96] = base[127:96] + 32'd1;
      upd[63:32]  = base[63:32] + len32;
    end
  end

  always_comb begin
    used_nxt      = used_r;
    scan_nxt      = scan_r;
    side_nxt      = side_r;
    drop_nxt      = drop_r;
    slot_nxt      = slot_r;
    miss_full_nxt = miss_full_r;
    new_ent_nxt   = new_ent_r;
    key_we    = 1'b0;
    key_waddr = used_r[AW-1:0];
    key_wdata = cur_key;
    key_raddr = scan_r[AW-1:0];
    cnt_we    = 1'b0;
    cnt_waddr = slot_r;
    cnt_wdata = upd;
    cnt_raddr = slot_r;
    case (state_r)
      TS_IDLE: begin
        scan_nxt = '0;
        side_nxt = 1'b0;
        drop_nxt = 1'b0;
        if (req.start) slot_nxt = AW'(req.idx);
      end
      TS_SCAN_REQ: begin
        if (scan_r < used_r) begin
          scan_nxt = scan_r + 1'b1;
        end else begin
          // Miss: insert at the end, or drop when full.
          if ({{(32-UW){1'b0}}, used_r} >= 32'(ENTRIES)) begin
            miss_full_nxt = 1'b1;
            drop_nxt      = 1'b1;
          end else begin
            miss_full_nxt = 1'b0;
            new_ent_nxt   = 1'b1;
            key_we        = 1'b1;
            slot_nxt      = used_r[AW-1:0];
            used_nxt      = used_r + 1'b1;
          end
        end
      end
      TS_SCAN_CHK: begin
        if (key_rdata_r == cur_key) begin
          slot_nxt      = scan_r[AW-1:0] - 1'b1;
          miss_full_nxt = 1'b0;
          new_ent_nxt   = 1'b0;
        end
      end
      TS_CNT_WR: begin
        cnt_we   = !miss_full_r;
        side_nxt = 1'b1;
        scan_nxt = '0;
        new_ent_nxt   = 1'b0;
        miss_full_nxt = 1'b0;
      end
      default: ;
    endcase
    // Hold the key read on the requested entry until the done cycle.
    if (state_r == TS_RD_WAIT || state_r == TS_RD_DATA) key_raddr = slot_r;
  end

  always_comb begin
    rsp      = '0;
    rsp.done = (state_r == TS_DONE);
    rsp.drop = drop_r;
    rsp.hit  = rd_ok;
    rsp.key  = 48'(key_rdata_r);
    rsp.cnt  = cnt_rdata_r;
  end
endmodule

### rtl/endpoint_traffic_counters.sv
// Top level: per-endpoint MAC/IP counters and a conversation list over packet headers.
// A read goes through the chosen table's or list's read path; an update waits for the slower
//   table's source then destination pass (key compare up to the match, an insert or a drop
//   on a miss, then the counter read-modify-write) and for the tuple scan. One item at a time:
//   the next transfer can land in the cycle after the result transfer. Reset: sync rst_n
//   clears fill counts and control.
module endpoint_traffic_counters #(
  parameter int MAC_ENTRIES  = etc_pkg::MAC_ENTRIES_DEF,
  parameter int IP_ENTRIES   = etc_pkg::IP_ENTRIES_DEF,
  parameter int CONV_ENTRIES = etc_pkg::CONV_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  etc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output etc_pkg::out_item_t out_data
);
  import etc_pkg::*;

  localparam int CAW = (CONV_ENTRIES > 1) ? $clog2(CONV_ENTRIES) : 1;
  localparam int CUW = $clog2(CONV_ENTRIES + 1);

  main_state_t ms_r, ms_nxt;
  in_item_t    item_r;
  out_item_t   res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_xfer;

  // Accept a new transfer only when idle and the result register is empty.
  assign in_stall  = (ms_r != MS_IDLE) || out_valid_r;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // Counter table requests
  tbl_req_t mreq, ireq;
  tbl_rsp_t mrsp, irsp;
  logic mdone_r, idone_r, cdone_r;
  logic mdrop_r, idrop_r, cdrop_r;
  tbl_rsp_t mhold_r, ihold_r;

  always_comb begin
    mreq       = '0;
    mreq.start = in_xfer && (in_data.command == CMD_UPDATE || in_data.command == CMD_READ_MAC);
    mreq.op    = (in_data.command == CMD_UPDATE) ? TOP_COUNT : TOP_READ;
    mreq.skey  = in_data.src_mac;
    mreq.dkey  = in_data.dst_mac;
    mreq.len   = in_data.frame_len;
    mreq.idx   = in_data.read_index;
    ireq       = '0;
    ireq.start = in_xfer && (in_data.command == CMD_UPDATE || in_data.command == CMD_READ_IP);
    ireq.op    = (in_data.command == CMD_UPDATE) ? TOP_COUNT : TOP_READ;
    ireq.skey  = {16'd0, in_data.src_ip};
    ireq.dkey  = {16'd0, in_data.dst_ip};
    ireq.len   = in_data.frame_len;
    ireq.idx   = in_data.read_index;
  end

  etc_table #(.ENTRIES(MAC_ENTRIES), .KEY_W(48)) u_mac (
    .clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp)
  );

  etc_table #(.ENTRIES(IP_ENTRIES), .KEY_W(32)) u_ip (
    .clk(clk), .rst_n(rst_n), .req(ireq), .rsp(irsp)
  );

  // Conversation list: tuple memory with serial scan, append and indexed read.
  logic [97:0] cnv_mem [CONV_ENTRIES];
  cnv_state_t  cs_r, cs_nxt;
  logic [CUW-1:0] cused_r, cused_nxt, cscan_r, cscan_nxt;
  logic [97:0] ctup_r, crd_r;
  logic        cwe;
  logic [CAW-1:0] craddr;
  logic        cstart;
  logic [97:0] tup_in;
  logic        l4_known;

  assign l4_known = (in_data.ip_proto == PROTO_TCP) || (in_data.ip_proto == PROTO_UDP);
  assign tup_in = {in_data.src_ip, in_data.dst_ip,
                   l4_known ? in_data.l4_src_port : 16'd0,
                   l4_known ? in_data.l4_dst_port : 16'd0,
                   l4_known ? ((in_data.ip_proto == PROTO_TCP) ? CLS_TCP : CLS_UDP)
                            : CLS_OTHER};
  assign cstart = in_xfer && (in_data.command == CMD_UPDATE || in_data.command == CMD_READ_CNV);
  assign craddr = (cs_r == CS_IDLE) ? CAW'(in_data.read_index) : cscan_r[CAW-1:0];

  always_ff @(posedge clk) begin
    if (cwe) cnv_mem[cused_r[CAW-1:0]] <= ctup_r;
    crd_r <= cnv_mem[craddr];
  end

  always_ff @(posedge clk) begin
    if (cstart) ctup_r <= tup_in;
  end

  logic cread_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r    <= CS_IDLE;
      cused_r <= '0;
      cscan_r <= '0;
      cread_r <= 1'b0;
    end else begin
      cs_r    <= cs_nxt;
      cused_r <= cused_nxt;
      cscan_r <= cscan_nxt;
      if (cstart) cread_r <= (in_data.command == CMD_READ_CNV);
    end
  end

  logic cfull;
  assign cfull = {{(32-CUW){1'b0}}, cused_r} >= 32'(CONV_ENTRIES);

  always_comb begin
    cs_nxt = cs_r;
    case (cs_r)
      CS_IDLE:    if (cstart) cs_nxt = (in_data.command == CMD_READ_CNV) ? CS_RD_WAIT : CS_REQ;
      CS_REQ:     cs_nxt = (cscan_r < cused_r) ? CS_CHK : CS_DONE;
      CS_CHK:     cs_nxt = (crd_r == ctup_r) ? CS_DONE : CS_REQ;
      CS_RD_WAIT: cs_nxt = CS_RD_DATA;
      CS_RD_DATA: cs_nxt = CS_DONE;
      CS_DONE:    cs_nxt = CS_IDLE;
      default:    cs_nxt = CS_IDLE;
    endcase
  end

  logic cdrop_nxt;
  always_comb begin
    cused_nxt = cused_r;
    cscan_nxt = cscan_r;
    cwe       = 1'b0;
    cdrop_nxt = 1'b0;
    case (cs_r)
      // A read parks the scan pointer on the requested entry; an update scans from zero.
      CS_IDLE: cscan_nxt = (cstart && in_data.command == CMD_READ_CNV)
                           ? CUW'(in_data.read_index) : '0;
      CS_REQ: begin
        if (cscan_r < cused_r) begin
          cscan_nxt = cscan_r + 1'b1;
        end else if (cfull) begin
          cdrop_nxt = 1'b1;
        end else begin
          cwe       = 1'b1;
          cused_nxt = cused_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Collect completions from the three engines.
  logic need_m, need_i, need_c;
  logic [7:0] ridx_r;
  logic cvalid_r;
  logic [97:0] crdh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mdone_r <= 1'b0; idone_r <= 1'b0; cdone_r <= 1'b0;
      cdrop_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        mdone_r <= !mreq.start;
        idone_r <= !ireq.start;
        cdone_r <= !cstart;
        cdrop_r <= 1'b0;
      end else begin
        if (mrsp.done) mdone_r <= 1'b1;
        if (irsp.done) idone_r <= 1'b1;
        if (cs_r == CS_DONE) cdone_r <= 1'b1;
        if (cdrop_nxt) cdrop_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mrsp.done) mhold_r <= mrsp;
    if (irsp.done) ihold_r <= irsp;
    if (cs_r == CS_RD_DATA) crdh_r <= crd_r;
    if (in_xfer) ridx_r <= in_data.read_index;
  end
  assign mdrop_r  = mhold_r.drop;
  assign idrop_r  = ihold_r.drop;
  assign need_m   = 1'b0;
  assign need_i   = 1'b0;
  assign need_c   = cread_r;
  assign cvalid_r = ({{(32-CUW){1'b0}}, cused_r} > {24'd0, ridx_r})
                 && ({24'd0, ridx_r} < 32'(CONV_ENTRIES));

  always_ff @(posedge clk) begin
    if (in_xfer) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r        <= MS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      ms_r        <= ms_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ms_r == MS_OUT) res_r <= res_nxt;
  end

  always_comb begin
    ms_nxt = ms_r;
    case (ms_r)
      MS_IDLE: if (in_xfer) ms_nxt = MS_RUN;
      MS_RUN:  ms_nxt = MS_WAIT;
      MS_WAIT: if (mdone_r && idone_r && cdone_r && !need_m && !need_i) ms_nxt = MS_OUT;
      MS_OUT:  ms_nxt = MS_IDLE;
      default: ms_nxt = MS_IDLE;
    endcase
  end

  // Drive the result register and its valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (ms_r == MS_OUT) out_valid_nxt = 1'b1;
    res_nxt = '0;
    case (item_r.command)
      CMD_UPDATE: begin
        res_nxt.entry_valid    = 1'b1;
        res_nxt.table_overflow = mdrop_r || idrop_r || cdrop_r;
      end
      CMD_READ_MAC: if (mhold_r.hit) begin
        res_nxt.entry_valid   = 1'b1;
        res_nxt.entry_address = mhold_r.key;
        res_nxt.tx_pkts       = mhold_r.cnt[127:96];
        res_nxt.tx_bytes      = mhold_r.cnt[63:32];
        res_nxt.rx_pkts       = mhold_r.cnt[95:64];
        res_nxt.rx_bytes      = mhold_r.cnt[31:0];
      end
      CMD_READ_IP: if (ihold_r.hit) begin
        res_nxt.entry_valid   = 1'b1;
        res_nxt.entry_address = ihold_r.key;
        res_nxt.tx_pkts       = ihold_r.cnt[127:96];
        res_nxt.tx_bytes      = ihold_r.cnt[63:32];
        res_nxt.rx_pkts       = ihold_r.cnt[95:64];
        res_nxt.rx_bytes      = ihold_r.cnt[31:0];
      end
      CMD_READ_CNV: if (cvalid_r && need_c) begin
        res_nxt.entry_valid   = 1'b1;
        res_nxt.conv_src_ip   = crdh_r[97:66];
        res_nxt.conv_dst_ip   = crdh_r[65:34];
        res_nxt.conv_src_port = crdh_r[33:18];
        res_nxt.conv_dst_port = crdh_r[17:2];
        res_nxt.conv_protocol = crdh_r[1:0];
      end
      default: ;
    endcase
  end
endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// Testbench: traffic counter tables checked against an in-bench table predictor.
module tb;
  import etc_pkg::*;

  localparam int TBL_MAC    = 0;
  localparam int TBL_IP     = 1;
  localparam int DEPTH      = 256;
  localparam int STALL_LIMIT = 40000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  endpoint_traffic_counters uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Shadow of the address tables (MAC and IP share one layout, keys zero extended).
  logic [47:0]  addr_keys [2][DEPTH];
  logic [127:0] addr_tally[2][DEPTH];   // {psent, precv, bsent, brecv}
  int           addr_used [2];
  // Shadow of the conversation list.
  logic [31:0]  conv_sip[DEPTH], conv_dip[DEPTH];
  logic [15:0]  conv_sport[DEPTH], conv_dport[DEPTH];
  logic [1:0]   conv_cls[DEPTH];
  int           conv_used;

  out_item_t pending_results[$];
  int  errors;
  int  sent_items, got_results, overflow_seen;
  int  snd_idle_pct, rcv_stall_pct;
  int  quiet_cycles;

  // Find or insert one key; 0 means the table is full and the key is dropped.
  function automatic bit find_or_add(int t, logic [47:0] key, output int slot);
    for (int i = 0; i < addr_used[t]; i++) begin
      if (addr_keys[t][i] == key) begin
        slot = i;
        return 1'b1;
      end
    end
    if (addr_used[t] >= DEPTH) return 1'b0;
    slot = addr_used[t];
    addr_keys[t][slot] = key;
    addr_tally[t][slot] = '0;
    addr_used[t]++;
    return 1'b1;
  endfunction

  // Count one packet against its source then its destination address.
  function automatic bit tally_packet(int t, logic [47:0] skey, logic [47:0] dkey,
                                      logic [15:0] len);
    int  s;
    bit  dropped;
    logic [31:0] ps, pr, bs, br;
    dropped = 1'b0;
    if (find_or_add(t, skey, s)) begin
      {ps, pr, bs, br} = addr_tally[t][s];
      ps = ps + 32'd1;
      bs = bs + {16'd0, len};
      addr_tally[t][s] = {ps, pr, bs, br};
    end else dropped = 1'b1;
    if (find_or_add(t, dkey, s)) begin
      {ps, pr, bs, br} = addr_tally[t][s];
      pr = pr + 32'd1;
      br = br + {16'd0, len};
      addr_tally[t][s] = {ps, pr, bs, br};
    end else dropped = 1'b1;
    return dropped;
  endfunction

  function automatic bit note_conversation(logic [31:0] sip, logic [31:0] dip,
                                           logic [15:0] sp, logic [15:0] dp,
                                           logic [1:0] cls);
    for (int i = 0; i < conv_used; i++) begin
      if (conv_sip[i] == sip && conv_dip[i] == dip && conv_sport[i] == sp &&
          conv_dport[i] == dp && conv_cls[i] == cls) return 1'b0;
    end
    if (conv_used >= DEPTH) return 1'b1;
    conv_sip[conv_used] = sip;
    conv_dip[conv_used] = dip;
    conv_sport[conv_used] = sp;
    conv_dport[conv_used] = dp;
    conv_cls[conv_used] = cls;
    conv_used++;
    return 1'b0;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    bit        ovf;
    logic [1:0]  cls;
    logic [15:0] sp, dp;
    int          t;
    r = '0;
    case (it.command)
      CMD_UPDATE: begin
        ovf = tally_packet(TBL_MAC, it.src_mac, it.dst_mac, it.frame_len);
        ovf |= tally_packet(TBL_IP, {16'd0, it.src_ip}, {16'd0, it.dst_ip}, it.frame_len);
        if (it.ip_proto == PROTO_TCP || it.ip_proto == PROTO_UDP) begin
          cls = (it.ip_proto == PROTO_TCP) ? CLS_TCP : CLS_UDP;
          sp = it.l4_src_port;
          dp = it.l4_dst_port;
        end else begin
          // Non TCP/UDP traffic collapses to one conversation per address pair.
          cls = CLS_OTHER;
          sp = '0;
          dp = '0;
        end
        ovf |= note_conversation(it.src_ip, it.dst_ip, sp, dp, cls);
        r.entry_valid = 1'b1;
        r.table_overflow = ovf;
      end
      CMD_READ_MAC, CMD_READ_IP: begin
        t = (it.command == CMD_READ_MAC) ? TBL_MAC : TBL_IP;
        if (it.read_index < addr_used[t]) begin
          r.entry_valid = 1'b1;
          r.entry_address = addr_keys[t][it.read_index];
          {r.tx_pkts, r.rx_pkts, r.tx_bytes, r.rx_bytes} =
            addr_tally[t][it.read_index];
        end
      end
      default: begin
        if (it.read_index < conv_used) begin
          r.entry_valid = 1'b1;
          r.conv_src_ip = conv_sip[it.read_index];
          r.conv_dst_ip = conv_dip[it.read_index];
          r.conv_src_port = conv_sport[it.read_index];
          r.conv_dst_port = conv_dport[it.read_index];
          r.conv_protocol = conv_cls[it.read_index];
        end
      end
    endcase
    return r;
  endfunction

  // Send one item: idle at random first, then hold valid until the transfer.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_result(it));
    sent_items++;
  endtask

  // Pause the sender until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t make_packet(logic [47:0] sm, logic [47:0] dm,
                                           logic [31:0] si, logic [31:0] di,
                                           logic [7:0] pr, logic [15:0] sp,
                                           logic [15:0] dp, logic [15:0] len);
    in_item_t it;
    it = '0;
    it.command = CMD_UPDATE;
    it.src_mac = sm;  it.dst_mac = dm;
    it.src_ip = si;   it.dst_ip = di;
    it.ip_proto = pr;
    it.l4_src_port = sp;  it.l4_dst_port = dp;
    it.frame_len = len;
    it.read_index = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_read(logic [1:0] cmd, logic [7:0] idx);
    in_item_t it;
    it = '0;
    it.command = cmd;
    it.read_index = idx;
    return it;
  endfunction

  // Read commands against empty tables, including the top index.
  task automatic test_empty_reads();
    send_item(make_read(CMD_READ_MAC, 8'd0));
    send_item(make_read(CMD_READ_IP, 8'd255));
    send_item(make_read(CMD_READ_CNV, 8'd0));
  endtask

  // Field extremes, each protocol class, same source and destination.
  task automatic test_directed_updates();
    send_item(make_packet('0, '1, '0, '1, PROTO_TCP, '1, '0, '1));
    send_item(make_packet('1, '0, '1, '0, PROTO_UDP, '0, '1, '0));
    send_item(make_packet('0, '1, '0, '1, 8'd1, 16'h1234, 16'h5678, 16'd64));
    // Another non TCP/UDP protocol on the same pair must land on the same conversation.
    send_item(make_packet('0, '1, '0, '1, 8'd255, '1, '1, 16'd1500));
    send_item(make_packet('0, '1, '0, '1, 8'd0, 16'h8001, 16'h0002, 16'd60));
    // Same address on both ends takes both counts in one entry.
    send_item(make_packet(48'h0a0b0c0d0e0f, 48'h0a0b0c0d0e0f, 32'hc0a80001,
                          32'hc0a80001, PROTO_TCP, 16'd80, 16'd80, 16'hffff));
    send_item(make_packet('1, '0, '1, '0, PROTO_UDP, '0, '1, 16'd1));
    for (int i = 0; i < 4; i++) begin
      send_item(make_read(CMD_READ_MAC, 8'(i)));
      send_item(make_read(CMD_READ_IP, 8'(i)));
      send_item(make_read(CMD_READ_CNV, 8'(i)));
    end
    send_item(make_read(CMD_READ_CNV, 8'd255));
  endtask

  // Mostly packets over a small address pool so counters accumulate, plus reads.
  task automatic test_random_traffic(int n);
    logic [47:0] mac_pool[12];
    logic [31:0] ip_pool[12];
    in_item_t    it;
    int          pick, lim;
    mac_pool[0] = '0;  mac_pool[1] = '1;
    ip_pool[0]  = '0;  ip_pool[1]  = '1;
    for (int i = 2; i < 12; i++) begin
      mac_pool[i] = {16'($urandom), 32'($urandom)};
      ip_pool[i]  = 32'($urandom);
    end
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        it = make_packet(mac_pool[$urandom_range(11)], mac_pool[$urandom_range(11)],
                         ip_pool[$urandom_range(11)], ip_pool[$urandom_range(11)],
                         8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        case ($urandom_range(2))
          0: it.ip_proto = PROTO_TCP;
          1: it.ip_proto = PROTO_UDP;
          default: ;
        endcase
        if ($urandom_range(9) == 0)
          it.src_mac = {16'($urandom), 32'($urandom)};
        // Random junk in the unused read index must not matter.
        it.read_index = 8'($urandom);
      end else begin
        it = make_read(CMD_READ_MAC + 2'($urandom_range(2)), 8'd0);
        lim = (it.command == CMD_READ_CNV) ? conv_used :
              addr_used[(it.command == CMD_READ_MAC) ? TBL_MAC : TBL_IP];
        it.read_index = ($urandom_range(7) == 0) ? 8'($urandom)
                                                 : 8'($urandom_range(lim + 1 > 255 ? 255 : lim + 1));
        // Unused header fields carry noise on reads.
        it.src_mac = {16'($urandom), 32'($urandom)};
        it.dst_ip = 32'($urandom);
        it.frame_len = 16'($urandom);
      end
      send_item(it);
    end
  endtask

  // Push distinct addresses until the MAC and IP tables overflow, then read the top.
  task automatic test_table_full();
    for (int i = 0; i < 140; i++) begin
      send_item(make_packet({16'hfade, 32'(2 * i)}, {16'hfade, 32'(2 * i + 1)},
                            32'h0a000000 + 32'(2 * i), 32'h0a000000 + 32'(2 * i + 1),
                            PROTO_UDP, 16'(i), 16'(i + 7), 16'(64 + i)));
    end
    drain_results();
    send_item(make_read(CMD_READ_MAC, 8'd255));
    send_item(make_read(CMD_READ_IP, 8'd255));
    send_item(make_read(CMD_READ_MAC, 8'd0));
    send_item(make_read(CMD_READ_CNV, 8'd139));
  endtask

  // Receiver: random stall, compare each transfer against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_results++;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (want.table_overflow) overflow_seen++;
          if (out_data.entry_valid !== want.entry_valid) begin
            $error("entry_valid exp %0h got %0h", want.entry_valid, out_data.entry_valid);
            errors++;
          end
          if (out_data.entry_address !== want.entry_address) begin
            $error("entry_address exp %0h got %0h", want.entry_address,
                   out_data.entry_address);
            errors++;
          end
          if (out_data.tx_pkts !== want.tx_pkts) begin
            $error("tx_pkts exp %0h got %0h", want.tx_pkts, out_data.tx_pkts);
            errors++;
          end
          if (out_data.rx_pkts !== want.rx_pkts) begin
            $error("rx_pkts exp %0h got %0h", want.rx_pkts, out_data.rx_pkts);
            errors++;
          end
          if (out_data.tx_bytes !== want.tx_bytes) begin
            $error("tx_bytes exp %0h got %0h", want.tx_bytes, out_data.tx_bytes);
            errors++;
          end
          if (out_data.rx_bytes !== want.rx_bytes) begin
            $error("rx_bytes exp %0h got %0h", want.rx_bytes, out_data.rx_bytes);
            errors++;
          end
          if (out_data.conv_src_ip !== want.conv_src_ip) begin
            $error("conv_src_ip exp %0h got %0h", want.conv_src_ip, out_data.conv_src_ip);
            errors++;
          end
          if (out_data.conv_dst_ip !== want.conv_dst_ip) begin
            $error("conv_dst_ip exp %0h got %0h", want.conv_dst_ip, out_data.conv_dst_ip);
            errors++;
          end
          if (out_data.conv_src_port !== want.conv_src_port) begin
            $error("conv_src_port exp %0h got %0h", want.conv_src_port,
                   out_data.conv_src_port);
            errors++;
          end
          if (out_data.conv_dst_port !== want.conv_dst_port) begin
            $error("conv_dst_port exp %0h got %0h", want.conv_dst_port,
                   out_data.conv_dst_port);
            errors++;
          end
          if (out_data.conv_protocol !== want.conv_protocol) begin
            $error("conv_protocol exp %0h got %0h", want.conv_protocol,
                   out_data.conv_protocol);
            errors++;
          end
          if (out_data.table_overflow !== want.table_overflow) begin
            $error("table_overflow exp %0h got %0h", want.table_overflow,
                   out_data.table_overflow);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    sent_items = 0;
    got_results = 0;
    overflow_seen = 0;
    addr_used[TBL_MAC] = 0;
    addr_used[TBL_IP] = 0;
    conv_used = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    snd_idle_pct = 21;
    rcv_stall_pct = 50;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_reads();
    test_directed_updates();
    test_random_traffic(130);
    drain_results();

    snd_idle_pct = 50;
    rcv_stall_pct = 21;
    test_random_traffic(130);
    test_table_full();

    // Tables full from here: new keys and tuples keep dropping.
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    test_random_traffic(130);

    drain_results();
    repeat (50) @(posedge clk);
    $display("covered %0d items, %0d results, %0d overflow updates; MAC %0d IP %0d conv %0d",
             sent_items, got_results, overflow_seen, addr_used[TBL_MAC], addr_used[TBL_IP],
             conv_used);
    $display("errors: %0d", errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/etc_pkg.sv
rtl/etc_table.sv
rtl/endpoint_traffic_counters.sv
verif/tb.sv
